// ===== rtl/bsc_pkg.sv =====
// Shared types, constants and arithmetic helpers for the barometer sample compensation block.
// No dependencies.
package bsc_pkg;

  localparam int RawW = 20;
  localparam logic [63:0] FineOffset = 64'd128000;
  localparam logic [63:0] FullScale  = 64'd1048576;
  localparam logic [63:0] ScaleK     = 64'd3125;
  localparam int QDepth = 4;
  localparam int QPtrW  = 2;
  // divider stages: magnitude stage plus one stage per quotient bit
  localparam int DivLat = 65;

  typedef enum logic [1:0] {
    REG_TEMP   = 2'd0,
    REG_PRESS0 = 2'd1,
    REG_PRESS1 = 2'd2,
    REG_PRESS2 = 2'd3
  } reg_idx_t;

  // Item handed from the front (temperature) to the back (pressure).
  typedef struct packed {
    logic [31:0] fine;
    logic [31:0] centi;
    logic [19:0] adcp;
  } fitem_t;

  typedef struct packed {
    logic [31:0] fine_temperature;
    logic [31:0] temperature_centi;
    logic [31:0] pressure_q24_8;
    logic        pressure_valid;
  } res_t;

  // Low 64 bits of a 64x64 product, built from 32x32 partial products.
  function automatic logic [63:0] mul64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ll;
    logic [31:0] lh, hl;
    ll = a[31:0] * b[31:0];
    lh = a[31:0] * b[63:32];
    hl = a[63:32] * b[31:0];
    return ll + {lh + hl, 32'd0};
  endfunction

endpackage

// ===== rtl/bsc_if.sv =====
// Valid/ready channel interface used for input, output and configuration.
// Depends on nothing.
interface bsc_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/bsc_front.sv =====
// Front part: accepts samples and computes fine temperature and centi-degrees.
// Depends on bsc_pkg.
module bsc_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [19:0]           raw_pressure,
  input  logic [19:0]           raw_temperature,
  input  logic [47:0]           temp_calib,
  output logic                  f_valid,
  input  logic                  f_ready,
  output bsc_pkg::fitem_t       f_item
);
  logic [15:0] t1;
  logic signed [31:0] t2, t3;
  logic v1_r, v2_r, v3_r;
  logic stall;
  // stage 1
  logic [31:0] a_r, b_r, a_nxt, b_nxt;
  logic [19:0] p1_r;
  // stage 2
  logic [31:0] v1_s2_r, bb_r;
  logic [19:0] p2_r;
  // stage 3
  logic [31:0] fine_r, fine_nxt;
  logic [19:0] p3_r;
  logic [63:0] m1, m2, m3;

  assign t1 = temp_calib[15:0];
  assign t2 = $signed(temp_calib[31:16]);
  assign t3 = $signed(temp_calib[47:32]);
  assign stall = v3_r && !f_ready;
  assign in_ready = !stall;

  assign a_nxt = {15'd0, raw_temperature[19:3]} - {15'd0, t1, 1'b0};
  assign b_nxt = {16'd0, raw_temperature[19:4]} - {16'd0, t1};
  assign m1 = {32'd0, a_r} * {32'd0, t2};
  assign m2 = {32'd0, b_r} * {32'd0, b_r};
  assign m3 = {32'd0, bb_r} * {32'd0, t3};
  assign fine_nxt = v1_s2_r + 32'($signed(m3[31:0]) >>> 14);

  // advance the pipeline unless the output is blocked
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
    end else if (!stall) begin
      v1_r <= in_valid; v2_r <= v1_r; v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      a_r <= a_nxt; b_r <= b_nxt; p1_r <= raw_pressure;
      v1_s2_r <= 32'($signed(m1[31:0]) >>> 11);
      bb_r <= 32'($signed(m2[31:0]) >>> 12);
      p2_r <= p1_r;
      fine_r <= fine_nxt; p3_r <= p2_r;
    end
  end

  logic [31:0] c5;
  assign c5 = (fine_r << 2) + fine_r + 32'd128;
  assign f_valid = v3_r;
  assign f_item.fine = fine_r;
  assign f_item.centi = 32'($signed(c5) >>> 8);
  assign f_item.adcp = p3_r;
endmodule

// ===== rtl/bsc_fifo.sv =====
// Short queue between front and back parts.
// Depends on bsc_pkg.
module bsc_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            w_valid,
  output logic            w_ready,
  input  bsc_pkg::fitem_t w_item,
  output logic            r_valid,
  input  logic            r_ready,
  output bsc_pkg::fitem_t r_item
);
  bsc_pkg::fitem_t mem_r [bsc_pkg::QDepth];
  logic [bsc_pkg::QPtrW-1:0] wp_r, rp_r;
  logic [bsc_pkg::QPtrW:0] cnt_r;
  logic wr, rd;

  assign w_ready = cnt_r != 3'(bsc_pkg::QDepth);
  assign r_valid = cnt_r != '0;
  assign wr = w_valid && w_ready;
  assign rd = r_valid && r_ready;
  assign r_item = mem_r[rp_r];

  // move pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {2'd0, wr} - {2'd0, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= w_item;
  end
endmodule

// ===== rtl/bsc_div.sv =====
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating.
// Depends on bsc_pkg.
module bsc_div (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic [63:0] quo
);
  logic [63:0] q_r [bsc_pkg::DivLat];
  logic [64:0] rem_r [bsc_pkg::DivLat];
  logic [63:0] d_r [bsc_pkg::DivLat];
  logic        neg_r [bsc_pkg::DivLat];

  // stage 0: take magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      q_r[0]   <= num[63] ? 64'(0 - num) : num;
      rem_r[0] <= '0;
      d_r[0]   <= den[63] ? 64'(0 - den) : den;
      neg_r[0] <= num[63] ^ den[63];
    end
  end

  // one restoring step per stage
  for (genvar i = 0; i < bsc_pkg::DivLat - 1; i++) begin : g_st
    logic [64:0] sh, df;
    assign sh = {rem_r[i][63:0], q_r[i][63]};
    assign df = sh - {1'b0, d_r[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1] <= df[64] ? sh : df;
        q_r[i+1]   <= {q_r[i][62:0], ~df[64]};
        d_r[i+1]   <= d_r[i];
        neg_r[i+1] <= neg_r[i];
      end
    end
  end

  assign quo = neg_r[bsc_pkg::DivLat-1] ? 64'(0 - q_r[bsc_pkg::DivLat-1])
                                        : q_r[bsc_pkg::DivLat-1];
endmodule

// ===== rtl/bsc_back.sv =====
// Back part: 64-bit pressure compensation pipeline with an output register.
// Depends on bsc_pkg and bsc_div.
module bsc_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_ready,
  input  bsc_pkg::fitem_t q_item,
  input  logic [63:0]     pc0,
  input  logic [63:0]     pc1,
  input  logic [15:0]     pc2,
  output logic            o_valid,
  input  logic            o_ready,
  output bsc_pkg::res_t   o_res
);
  logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  assign p1 = {48'd0, pc0[15:0]};
  assign p2 = 64'($signed(pc0[31:16]));
  assign p3 = 64'($signed(pc0[47:32]));
  assign p4 = 64'($signed(pc0[63:48]));
  assign p5 = 64'($signed(pc1[15:0]));
  assign p6 = 64'($signed(pc1[31:16]));
  assign p7 = 64'($signed(pc1[47:32]));
  assign p8 = 64'($signed(pc1[63:48]));
  assign p9 = 64'($signed(pc2));

  logic en;
  logic [bsc_pkg::DivLat+11:0] v_r;
  assign en = !(v_r[bsc_pkg::DivLat+11] && !o_ready) ;
  assign q_ready = en;

  // valid shift line
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (en) v_r <= {v_r[bsc_pkg::DivLat+10:0], q_valid};
  end

  // S1: q1, pp
  logic [63:0] s1_q1, s1_pp;
  // S2: products
  logic [63:0] s2_qq, s2_q1p5, s2_q1p2, s2_pp;
  // S3
  logic [63:0] s3_qqp6, s3_qqp3, s3_a, s3_b, s3_pp;
  // S4
  logic [63:0] s4_q2, s4_v1, s4_pp;
  // S5
  logic [63:0] s5_x, s5_q2, s5_pp;
  // S6: divisor, numerator part
  logic [63:0] s6_q1, s6_n;
  // S7: numerator
  logic [63:0] s7_q1, s7_n;
  always_ff @(posedge clk) begin
    if (en) begin
      s1_q1 <= 64'($signed(q_item.fine)) - bsc_pkg::FineOffset;
      s1_pp <= bsc_pkg::FullScale - {44'd0, q_item.adcp};
      s2_qq <= bsc_pkg::mul64(s1_q1, s1_q1);
      s2_q1p5 <= bsc_pkg::mul64(s1_q1, p5);
      s2_q1p2 <= bsc_pkg::mul64(s1_q1, p2);
      s2_pp <= s1_pp;
      s3_qqp6 <= bsc_pkg::mul64(s2_qq, p6);
      s3_qqp3 <= bsc_pkg::mul64(s2_qq, p3);
      s3_a <= s2_q1p5 << 17;
      s3_b <= s2_q1p2 << 12;
      s3_pp <= s2_pp;
      s4_q2 <= s3_qqp6 + s3_a + (p4 << 35);
      s4_v1 <= 64'($signed(s3_qqp3) >>> 8) + s3_b;
      s4_pp <= s3_pp;
      s5_x <= (64'd1 << 47) + s4_v1;
      s5_q2 <= s4_q2;
      s5_pp <= s4_pp;
      s6_q1 <= 64'($signed(bsc_pkg::mul64(s5_x, p1)) >>> 33);
      s6_n <= (s5_pp << 31) - s5_q2;
      s7_q1 <= s6_q1;
      s7_n <= bsc_pkg::mul64(s6_n, bsc_pkg::ScaleK);
    end
  end

  // carry temperature and zero flag alongside the divider
  logic [63:0] tq_r [bsc_pkg::DivLat+11];
  logic        zq_r [bsc_pkg::DivLat];
  always_ff @(posedge clk) begin
    if (en) begin
      tq_r[0] <= {q_item.fine, q_item.centi};
      for (int i = 1; i < bsc_pkg::DivLat + 11; i++) tq_r[i] <= tq_r[i-1];
      zq_r[0] <= s7_q1 == '0;
      for (int i = 1; i < bsc_pkg::DivLat; i++) zq_r[i] <= zq_r[i-1];
    end
  end

  logic [63:0] dq;
  bsc_div u_div (.clk(clk), .en(en), .num(s7_n), .den(s7_q1), .quo(dq));

  // post-division: h, products, sum
  logic [63:0] d1_pp, d1_h, d2_pp, d2_ph, d2_r2, d3_pp, d3_r1, d3_r2, d4_p;
  logic [63:0] d2_h;
  logic d1_z, d2_z, d3_z, d4_z;
  always_ff @(posedge clk) begin
    if (en) begin
      d1_pp <= dq; d1_h <= 64'($signed(dq) >>> 13); d1_z <= zq_r[bsc_pkg::DivLat-1];
      d2_pp <= d1_pp; d2_h <= d1_h; d2_z <= d1_z;
      d2_ph <= bsc_pkg::mul64(p9, d1_h);
      d2_r2 <= 64'($signed(bsc_pkg::mul64(p8, d1_pp)) >>> 19);
      d3_pp <= d2_pp; d3_z <= d2_z; d3_r2 <= d2_r2;
      d3_r1 <= 64'($signed(bsc_pkg::mul64(d2_ph, d2_h)) >>> 25);
      d4_z <= d3_z;
      d4_p <= 64'($signed(d3_pp + d3_r1 + d3_r2) >>> 8) + (p7 << 4);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      o_res.fine_temperature  <= tq_r[bsc_pkg::DivLat+10][63:32];
      o_res.temperature_centi <= tq_r[bsc_pkg::DivLat+10][31:0];
      o_res.pressure_q24_8    <= d4_z ? 32'd0 : d4_p[31:0];
      o_res.pressure_valid    <= !d4_z;
    end
  end
  assign o_valid = v_r[bsc_pkg::DivLat+11];
endmodule

// ===== rtl/barometer_sample_compensation.sv =====
// Top level of the barometer sample compensation block.
// Depends on bsc_pkg, bsc_if, bsc_front, bsc_fifo, bsc_back, bsc_div.
//
// Usage: raw pressure/temperature pairs enter on the in channel (valid/ready),
// calibration words are written on the cfg channel (index 0..3, always ready),
// and one result per sample leaves on the out channel.
// Throughput: one sample per cycle while the receiver keeps out_ch.ready high.
// Register stages between the accepting edge and the result: 3 in the
// temperature front, one in the queue and 77 in the pressure back end
// (7 arithmetic stages, the 65-stage bit-per-stage divider, 4 stages after
// it and the output register).
// Reset clears all calibration registers to zero and empties every pipeline.
// When the receiver stalls, the back end freezes; the queue absorbs the
// front's in-flight samples, then the front freezes and in_ready drops.
module barometer_sample_compensation (
  input logic clk,
  input logic rst_n,
  bsc_if.sink   in_ch,
  bsc_if.source out_ch,
  bsc_if.sink   cfg_ch
);
  logic [47:0] temp_r;
  logic [63:0] pc0_r, pc1_r;
  logic [15:0] pc2_r;
  logic [1:0]  cidx;

  // calibration register writes; index field is data[65:64]
  assign cfg_ch.ready = 1'b1;
  assign cidx = cfg_ch.data[65:64];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_r <= '0; pc0_r <= '0; pc1_r <= '0; pc2_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (bsc_pkg::reg_idx_t'(cidx))
        bsc_pkg::REG_TEMP:   temp_r <= cfg_ch.data[47:0];
        bsc_pkg::REG_PRESS0: pc0_r <= cfg_ch.data[63:0];
        bsc_pkg::REG_PRESS1: pc1_r <= cfg_ch.data[63:0];
        bsc_pkg::REG_PRESS2: pc2_r <= cfg_ch.data[15:0];
        default: ;
      endcase
    end
  end

  logic f_valid, f_ready, q_valid, q_ready;
  bsc_pkg::fitem_t f_item, q_item;
  bsc_pkg::res_t res;

  bsc_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .raw_pressure(in_ch.data[39:20]), .raw_temperature(in_ch.data[19:0]),
    .temp_calib(temp_r),
    .f_valid(f_valid), .f_ready(f_ready), .f_item(f_item)
  );

  bsc_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .w_valid(f_valid), .w_ready(f_ready), .w_item(f_item),
    .r_valid(q_valid), .r_ready(q_ready), .r_item(q_item)
  );

  bsc_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .pc0(pc0_r), .pc1(pc1_r), .pc2(pc2_r),
    .o_valid(out_ch.valid), .o_ready(out_ch.ready), .o_res(res)
  );

  assign out_ch.data = res;
endmodule
